@@ hw/rtl/slie_pkg.sv @@
// Shared types, constants and the opcode decode table for the integer
// expression evaluator. No dependencies; the top level, slie_ctrl and slie_dp import it.
package slie_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int IDX_W   = (SLOT_W + 1 > 12) ? SLOT_W + 1 : 12;
    localparam int RAM_W   = 65;
    localparam int CNT_W   = 11;
    localparam int STEP_W  = 6;
    localparam int NUM_OPS = 17;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(2);
    localparam logic [STEP_W-1:0] DIV_LAST  = '1;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_SET   = 2'd1,
        REQ_EXEC  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DIVZERO = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FULL    = 3'd3,
        ST_BADOP   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        K_ADD = 3'd0,
        K_SUB = 3'd1,
        K_MUL = 3'd2,
        K_DIV = 3'd3,
        K_MOD = 3'd4,
        K_MIN = 3'd5,
        K_MAX = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  left_slot;
        logic  right_slot;
    } op_desc_t;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic in_ready;
        logic set_err;
        logic wr_var;
        logic rd_left;
        logic rd_right;
        logic latch_b;
        logic alu;
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic set_divz;
        logic fix;
        logic wr_dest;
        logic out_load;
        logic clr_step;
    } dp_cmd_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic  req_valid;
        req_t  req_type;
        logic  err;
        logic  full;
        kind_t kind;
        logic  b_zero;
        logic  mul_last;
        logic  div_last;
        logic  clr_last;
        logic  out_busy;
    } dp_stat_t;

    function automatic op_desc_t decode_op(input logic [4:0] code);
        op_desc_t d;
        d = '{kind: K_ADD, left_slot: 1'b0, right_slot: 1'b0};
        unique case (code)
            5'd0:  d = '{K_ADD, 1'b1, 1'b1};
            5'd1:  d = '{K_ADD, 1'b1, 1'b0};
            5'd2:  d = '{K_SUB, 1'b1, 1'b1};
            5'd3:  d = '{K_SUB, 1'b1, 1'b0};
            5'd4:  d = '{K_SUB, 1'b0, 1'b1};
            5'd5:  d = '{K_MUL, 1'b1, 1'b1};
            5'd6:  d = '{K_MUL, 1'b1, 1'b0};
            5'd7:  d = '{K_DIV, 1'b1, 1'b1};
            5'd8:  d = '{K_DIV, 1'b1, 1'b0};
            5'd9:  d = '{K_DIV, 1'b0, 1'b1};
            5'd10: d = '{K_MOD, 1'b1, 1'b1};
            5'd11: d = '{K_MOD, 1'b1, 1'b0};
            5'd12: d = '{K_MOD, 1'b0, 1'b1};
            5'd13: d = '{K_MIN, 1'b1, 1'b1};
            5'd14: d = '{K_MIN, 1'b1, 1'b0};
            5'd15: d = '{K_MAX, 1'b1, 1'b1};
            5'd16: d = '{K_MAX, 1'b1, 1'b0};
            default: d = '{K_ADD, 1'b0, 1'b0};
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/slie_if.sv @@
// Valid/ready channel interfaces for request and result items.
// No dependencies.
interface slie_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [9:0]         var_index;
    logic signed [63:0] var_value;
    logic [4:0]         op_code;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;

    modport source (output valid, req_type, var_index, var_value, op_code,
                    left_operand, right_operand, input ready);
    modport sink   (input valid, req_type, var_index, var_value, op_code,
                    left_operand, right_operand, output ready);
endinterface

interface slie_rsp_if;
    logic               valid;
    logic               ready;
    logic [9:0]         dest_slot;
    logic signed [63:0] result_value;
    logic [2:0]         status;

    modport source (output valid, dest_slot, result_value, status, input ready);
    modport sink   (input valid, dest_slot, result_value, status, output ready);
endinterface

@@ hw/rtl/straight_line_int_expr_evaluator.sv @@
// Top level of the straight-line signed 64-bit expression evaluator.
// Depends on slie_pkg, slie_if, slie_ctrl and slie_dp (which holds slie_ram).
// Div and mod compute one quotient bit per cycle in the shared divider.
// Throughput: one item at a time; the next item is taken once the result is in the
//   output register, but its own result waits until the waiting one is taken.
// Reset: async active low; a clearing pass over the SLOTS (1024) slots follows
//   reset and every begin item, with no item accepted; config writes are taken.
module straight_line_int_expr_evaluator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [slie_pkg::CNT_W-1:0] cfg_wdata,
    slie_req_if.sink                   req,
    slie_rsp_if.source                 rsp
);
    import slie_pkg::*;

    // controller and datapath talk only through these two structs
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     accept;

    // sequencer: decode, operand reads, compute, write back, hand off item
    slie_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: store, arithmetic units and the output register
    slie_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat),
        .accept    (accept)
    );

    // items are taken only in idle, and idle is left only once an item is taken
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> cmd.in_ready)
        else $error("item taken while busy");
endmodule

@@ hw/rtl/slie_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hw/rtl/slie_ctrl.sv @@
// Sequencing state machine of the evaluator.
// Depends on slie_pkg (command and status structs).
module slie_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  slie_pkg::dp_stat_t stat,
    output slie_pkg::dp_cmd_t  cmd
);
    import slie_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_DECODE = 12'b000000000100,
        S_RD_L   = 12'b000000001000,
        S_RD_R   = 12'b000000010000,
        S_RD_W   = 12'b000000100000,
        S_EXEC   = 12'b000001000000,
        S_MUL    = 12'b000010000000,
        S_DIV    = 12'b000100000000,
        S_FIX    = 12'b001000000000,
        S_WRITE  = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // hold here until an item is taken
                cmd.in_ready = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.req_type)
                    REQ_BEGIN: state_next = S_CLEAR;
                    REQ_SET:
                    begin
                        cmd.wr_var = 1'b1;
                        state_next = S_IDLE;
                    end
                    REQ_EXEC:
                    begin
                        if (stat.err)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = stat.full ? S_OUT : S_WRITE;
                        end
                        else
                        begin
                            state_next = S_RD_L;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_RD_L:
            begin
                cmd.rd_left = 1'b1;
                state_next  = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.rd_right = 1'b1;
                state_next   = S_RD_W;
            end
            S_RD_W:
            begin
                cmd.latch_b = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (stat.kind)
                    K_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = S_MUL;
                    end
                    K_DIV, K_MOD:
                    begin
                        if (stat.b_zero)
                        begin
                            cmd.set_divz = 1'b1;
                            state_next   = S_WRITE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default:
                    begin
                        cmd.alu    = 1'b1;
                        state_next = S_WRITE;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_dest = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/slie_dp.sv @@
// Datapath: value store, operand registers, ALU, shared 32x32 multiplier,
// radix-2 divider and result register. Depends on slie_pkg, slie_if, slie_ram.
module slie_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [slie_pkg::CNT_W-1:0]   cfg_wdata,
    slie_req_if.sink                     req,
    slie_rsp_if.source                   rsp,
    input  slie_pkg::dp_cmd_t            cmd,
    output slie_pkg::dp_stat_t           stat,
    output logic                         accept
);
    import slie_pkg::*;

    logic [1:0]        req_type_reg;
    logic [9:0]        var_index_reg;
    logic [63:0]       var_value_reg;
    logic [4:0]        op_code_reg;
    logic [63:0]       lhs_reg;
    logic [63:0]       rhs_reg;
    logic [CNT_W-1:0]  var_count_reg;
    logic [CNT_W-1:0]  op_cnt_reg;
    logic [SLOT_W-1:0] clr_addr_reg;
    logic [63:0]       a_reg, b_reg, res_reg;
    logic [63:0]       rem_reg, quo_reg, dvs_reg;
    logic [STEP_W-1:0] step_reg;
    status_t           status_reg;
    logic [9:0]        dslot_reg;
    logic              out_valid_reg;
    logic [9:0]        out_dest_reg;
    logic [63:0]       out_res_reg;
    status_t           out_status_reg;

    op_desc_t          desc;
    logic              bad_op, full, range_err, var_ok;
    logic [IDX_W-1:0]  dest;
    status_t           err_code;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    logic [63:0]       slot_val, alu_res;
    logic [31:0]       mul_x, mul_y;
    logic [63:0]       mul_p;
    logic [64:0]       div_sh, div_diff;
    logic [63:0]       mod_r, fix_res;

    assign accept    = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;

    assign desc   = decode_op(op_code_reg);
    assign bad_op = op_code_reg >= 5'(NUM_OPS);
    assign dest   = IDX_W'(var_count_reg) + IDX_W'(op_cnt_reg);
    assign full   = (dest >= IDX_W'(SLOTS)) || (op_cnt_reg == CNT_MAX);
    assign range_err = (desc.left_slot && lhs_reg >= 64'(SLOTS))
                    || (desc.right_slot && rhs_reg >= 64'(SLOTS));
    assign var_ok = (CNT_W'(var_index_reg) < var_count_reg)
                 && (IDX_W'(var_index_reg) < IDX_W'(SLOTS));

    always_comb
    begin
        priority if (bad_op)  err_code = ST_BADOP;
        else if (full)        err_code = ST_FULL;
        else if (range_err)   err_code = ST_RANGE;
        else                  err_code = ST_OK;
    end

    // value store: bit 64 marks a written slot
    assign ram_we    = cmd.clr_step || cmd.wr_dest || (cmd.wr_var && var_ok);
    assign ram_waddr = cmd.clr_step ? clr_addr_reg
                     : cmd.wr_dest  ? SLOT_W'(dest) : SLOT_W'(var_index_reg);
    assign ram_wdata = cmd.clr_step ? '0
                     : cmd.wr_dest  ? {1'b1, res_reg} : {1'b1, var_value_reg};
    assign ram_re    = cmd.rd_left || cmd.rd_right;
    assign ram_raddr = cmd.rd_left ? SLOT_W'(lhs_reg) : SLOT_W'(rhs_reg);
    assign slot_val  = ram_rdata[64] ? ram_rdata[63:0] : 64'd0;

    slie_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (desc.kind)
            K_SUB:   alu_res = a_reg - b_reg;
            K_MIN:   alu_res = ($signed(b_reg) < $signed(a_reg)) ? b_reg : a_reg;
            K_MAX:   alu_res = ($signed(a_reg) < $signed(b_reg)) ? b_reg : a_reg;
            default: alu_res = a_reg + b_reg;
        endcase
    end

    // low 64 bits of the product from three 32x32 partial products
    always_comb
    begin
        if (cmd.mul_start)
        begin
            mul_x = a_reg[31:0];
            mul_y = b_reg[31:0];
        end
        else if (step_reg == STEP_W'(1))
        begin
            mul_x = a_reg[31:0];
            mul_y = b_reg[63:32];
        end
        else
        begin
            mul_x = a_reg[63:32];
            mul_y = b_reg[31:0];
        end
    end
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    assign div_sh   = {rem_reg, quo_reg[63]};
    assign div_diff = div_sh - {1'b0, dvs_reg};
    assign mod_r    = a_reg[63] ? (64'd0 - rem_reg) : rem_reg;
    assign fix_res  = (desc.kind == K_DIV)
                    ? ((a_reg[63] ^ b_reg[63]) ? (64'd0 - quo_reg) : quo_reg)
                    : (mod_r[63] ? (mod_r + b_reg) : mod_r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg <= '0;
            op_cnt_reg    <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            req_type_reg  <= REQ_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                var_count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                req_type_reg <= req.req_type;
                if (req.req_type == REQ_BEGIN)
                begin
                    op_cnt_reg   <= '0;
                    clr_addr_reg <= '0;
                end
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.wr_dest)
            begin
                op_cnt_reg <= op_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            var_index_reg <= req.var_index;
            var_value_reg <= req.var_value;
            op_code_reg   <= req.op_code;
            lhs_reg       <= req.left_operand;
            rhs_reg       <= req.right_operand;
        end
        if (cmd.set_err)
        begin
            res_reg    <= '0;
            status_reg <= err_code;
            dslot_reg  <= '0;
        end
        if (cmd.rd_right)
        begin
            a_reg <= desc.left_slot ? slot_val : lhs_reg;
        end
        if (cmd.latch_b)
        begin
            b_reg <= desc.right_slot ? slot_val : rhs_reg;
        end
        if (cmd.alu)
        begin
            res_reg    <= alu_res;
            status_reg <= ST_OK;
        end
        if (cmd.mul_start)
        begin
            res_reg    <= mul_p;
            status_reg <= ST_OK;
            step_reg   <= STEP_W'(1);
        end
        if (cmd.mul_step)
        begin
            res_reg  <= res_reg + {mul_p[31:0], 32'd0};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.set_divz)
        begin
            res_reg    <= '0;
            status_reg <= ST_DIVZERO;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= a_reg[63] ? (64'd0 - a_reg) : a_reg;
            dvs_reg  <= b_reg[63] ? (64'd0 - b_reg) : b_reg;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (!div_diff[64])
            begin
                rem_reg <= div_diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_sh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.fix)
        begin
            res_reg    <= fix_res;
            status_reg <= ST_OK;
        end
        if (cmd.wr_dest)
        begin
            dslot_reg <= 10'(dest);
        end
        if (cmd.out_load)
        begin
            out_dest_reg   <= dslot_reg;
            out_res_reg    <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.dest_slot    = out_dest_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.status       = out_status_reg;

    assign stat.req_valid = req.valid;
    assign stat.req_type  = req_t'(req_type_reg);
    assign stat.err       = err_code != ST_OK;
    assign stat.full      = full;
    assign stat.kind      = desc.kind;
    assign stat.b_zero    = b_reg == 64'd0;
    assign stat.mul_last  = step_reg == MUL_LAST;
    assign stat.div_last  = step_reg == DIV_LAST;
    assign stat.clr_last  = clr_addr_reg == SLOT_W'(SLOTS - 1);
    assign stat.out_busy  = out_valid_reg && !rsp.ready;

    a_dest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_dest |-> dest < IDX_W'(SLOTS))
        else $error("destination slot write beyond store");

    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_BEGIN |=> op_cnt_reg == '0)
        else $error("begin did not clear operation count");

    a_count_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_dest && !cfg_we |=> op_cnt_reg == $past(op_cnt_reg) + 1'b1)
        else $error("operation count did not advance on slot write");
endmodule
